// ===== sv/fgn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fgn_pkg;

   localparam int TableSize     = 256;
   localparam int IdxW          = $clog2(TableSize);
   localparam int MaxOctaves    = 8;
   localparam int CoordFracBits = 16;
   localparam int FracDown      = (CoordFracBits >= 16) ? CoordFracBits - 16 : 0;
   localparam int FracUp        = (CoordFracBits < 16) ? 16 - CoordFracBits : 0;
   localparam logic [17:0] OneQ16 = 18'd65536;

   // configuration register indexes
   localparam logic [1:0] CSR_THREE_D     = 2'd0;
   localparam logic [1:0] CSR_OCTAVES     = 2'd1;
   localparam logic [1:0] CSR_PERSISTENCE = 2'd2;
   localparam logic [1:0] CSR_LACUNARITY  = 2'd3;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   // table access requested by the sequencer
   typedef struct packed {
      logic            rd_en;
      logic [IdxW-1:0] rd_addr;
      logic            wr_en;
      logic [IdxW-1:0] wr_addr;
      logic [7:0]      wr_data;
   } tbl_req_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SCALE_LO, ST_SCALE_HI, ST_SPLIT, ST_FADE1, ST_FADE2, ST_FADE3,
      ST_FADE4, ST_HASH_ISSUE, ST_HASH_WAIT, ST_GRAD, ST_LERP_MUL, ST_LERP_ADD,
      ST_ACC, ST_NEXT, ST_DIV, ST_DONE
   } state_type;

   // 2D gradient: x and z terms
   function automatic logic signed [19:0] grad2(input logic [2:0] h,
         input logic signed [17:0] x, input logic signed [17:0] z);
      logic signed [19:0] xe, ze, r;
      xe = 20'(x);
      ze = 20'(z);
      unique case (h)
         3'd0: r = xe + ze;
         3'd1: r = -xe + ze;
         3'd2: r = xe - ze;
         3'd3: r = -xe - ze;
         3'd4: r = xe;
         3'd5: r = -xe;
         3'd6: r = ze;
         default: r = -ze;
      endcase
      return r;
   endfunction

   // 3D gradient: hash modulo 12 selects the edge direction
   function automatic logic signed [19:0] grad3(input logic [7:0] h,
         input logic signed [17:0] x, input logic signed [17:0] y,
         input logic signed [17:0] z);
      logic signed [19:0] xe, ye, ze, r;
      logic [15:0] q;
      logic [3:0] m;
      xe = 20'(x);
      ye = 20'(y);
      ze = 20'(z);
      // h * 171 >> 11 equals h / 12 for every 8-bit h
      q  = (16'(h) * 16'd171) >> 11;
      m  = 4'(16'(h) - q * 16'd12);
      unique case (m)
         4'd0: r = xe + ye;
         4'd1: r = -xe + ye;
         4'd2: r = xe - ye;
         4'd3: r = -xe - ye;
         4'd4: r = xe + ze;
         4'd5: r = -xe + ze;
         4'd6: r = xe - ze;
         4'd7: r = -xe - ze;
         4'd8: r = ye + ze;
         4'd9: r = -ye + ze;
         4'd10: r = ye - ze;
         default: r = -ye - ze;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/fractal_gradient_noise.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Fractal gradient noise over a 256-entry permutation table.
// Requests: start/busy with req_cmd. A load request (cmd 0) writes one table
// entry at its accepting edge, with no response; the next request may follow
// in the next cycle. An evaluate request (cmd 1) takes a Q16.16 point and
// returns one rsp_noise_value, Q1.15, on a single-cycle rsp_valid strobe;
// the receiver cannot stall.
// Each evaluate runs, per octave, a setup per axis (3 axes in 3D, 2 in 2D),
// a hash per corner (8 corners with three table reads in 3D, 4 corners with
// two in 2D) and a gradient, the lerps (7 in 3D, 3 in 2D) and accumulation;
// then the final divide, one quotient bit per cycle, and the output register.
// Zero octaves skip the octave loop and the divide and respond with zero.
// The single table read port sets hash time.
// One request is in flight at a time; busy is high until its response, and
// the next request can be accepted in the response cycle.
// CSR writes (csr_valid/csr_ready) are accepted whenever the block is idle.
// Reset restores the register defaults; the table is undefined until loaded.
module fractal_gradient_noise (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire                 req_cmd,
   input  wire  [7:0]          req_table_index,
   input  wire  [7:0]          req_table_value,
   input  wire  signed [31:0]  req_coord_x,
   input  wire  signed [31:0]  req_coord_y,
   input  wire  signed [31:0]  req_coord_z,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_noise_value,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [1:0]          csr_index,
   input  wire  [15:0]         csr_data
);
   import fgn_pkg::*;

   // configuration
   logic        three_d_ff;
   logic [3:0]  octaves_ff;
   logic [15:0] persist_ff, lacun_ff;

   assign csr_ready = ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         three_d_ff <= 1'b1;
         octaves_ff <= 4'd4;
         persist_ff <= 16'd32768;
         lacun_ff   <= 16'd8192;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_THREE_D:     three_d_ff <= csr_data[0];
            CSR_OCTAVES:     octaves_ff <= csr_data[3:0];
            CSR_PERSISTENCE: persist_ff <= csr_data;
            CSR_LACUNARITY:  lacun_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // datapath registers
   state_type state_ff, state_in;
   logic signed [31:0] cx_ff [3];
   logic        dim3_ff;
   logic [3:0]  oct_left_ff;
   logic [31:0] freq_ff;
   logic [16:0] amp_ff;
   logic [20:0] amp_sum_ff;
   logic signed [52:0] total_ff;
   logic [1:0]  axis_ff;
   logic signed [47:0] prod_lo_ff;
   logic signed [63:0] scaled_ff;
   logic [7:0]  cell_ff [3];
   logic [15:0] loc_ff [3];
   logic [16:0] fade_ff [3];
   logic [31:0] t2_ff, t3_ff;
   logic signed [33:0] poly_ff;
   logic [3:0]  corner_ff;
   logic [1:0]  hstep_ff;
   logic [7:0]  hacc_ff;
   logic signed [19:0] cval_ff [8];
   logic [2:0]  lidx_ff;
   logic signed [40:0] lprod_ff;
   logic signed [19:0] octval_ff;
   logic        neg_ff;

   tbl_req_type tbl_req;
   logic [7:0]  tbl_rd;

   fgn_table u_table (.clock(clock), .req(tbl_req), .rd_data(tbl_rd));

   logic        div_start, div_done;
   logic [52:0] div_num, div_quot;
   fgn_divider u_div (.clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den({amp_sum_ff, 1'b0}), .done(div_done),
      .quot(div_quot));

   // helpers
   logic        acc;
   logic [1:0]  axis_sel;
   logic [7:0]  c_sel;
   logic [2:0]  corner_bits;
   logic [1:0]  last_step;
   logic signed [17:0] lx, ly, lz;
   logic signed [19:0] gval;
   logic signed [19:0] la, lb;
   logic [16:0] lt;
   logic [2:0]  lo_a;
   logic [3:0]  oct_sat;
   logic signed [47:0] mul_lo;
   logic signed [48:0] mul_hi;
   logic [47:0] freq_next;
   logic [32:0] amp_next;
   logic signed [40:0] lprod_c;
   logic signed [20:0] ldiff;
   logic signed [20:0] lres;
   logic signed [38:0] wprod;
   logic [63:0] scaled_u;
   logic [15:0] frac16;
   logic signed [34:0] poly_c;
   logic [50:0] fade_full;
   logic [33:0] t2c;
   logic [47:0] t3c;
   logic [16:0] fade_sat;
   logic signed [52:0] total_next;
   logic [52:0] abs_total;
   logic signed [53:0] res_s;

   assign acc  = start && !busy;
   assign busy = (state_ff != ST_IDLE);

   assign oct_sat   = (octaves_ff > 4'(MaxOctaves)) ? 4'(MaxOctaves) : octaves_ff;
   assign last_step = dim3_ff ? 2'd2 : 2'd1;
   // 2D uses axes x (0) and z (2); corner bit 1 selects z then
   assign corner_bits = dim3_ff ? corner_ff[2:0] : {corner_ff[1], 1'b0, corner_ff[0]};
   assign axis_sel = dim3_ff ? hstep_ff : (hstep_ff == 2'd0 ? 2'd0 : 2'd2);

   always_comb begin
      c_sel = cell_ff[axis_sel] + 8'(corner_bits[axis_sel]);
   end

   // scaling multiplies split into 16-bit halves of the frequency
   assign mul_lo = cx_ff[axis_ff] * $signed({1'b0, freq_ff[15:0]});
   assign mul_hi = cx_ff[axis_ff] * $signed({1'b0, freq_ff[31:16]});
   assign scaled_u = 64'(scaled_ff);
   assign frac16 = 16'((scaled_u[CoordFracBits-1:0] >> FracDown) << FracUp);

   // fade polynomial pieces
   assign t2c = {18'd0, loc_ff[axis_ff]} * {18'd0, loc_ff[axis_ff]};
   assign t3c = 48'(t2_ff) * 48'(loc_ff[axis_ff]);
   // 6*t*t >> 16, taken from the full square
   assign poly_c = $signed(35'((37'(t2c) * 37'd6) >> 16));
   assign fade_full = 51'(t3_ff) * 51'(poly_ff[33:0]);
   assign fade_sat = (fade_full[50:16] > 35'd65536) ? 17'd65536 : 17'(fade_full[32:16]);

   // gradient at the current corner
   assign lx = $signed({2'b0, loc_ff[0]}) - (corner_bits[0] ? $signed(OneQ16) : 18'sd0);
   assign ly = $signed({2'b0, loc_ff[1]}) - (corner_bits[1] ? $signed(OneQ16) : 18'sd0);
   assign lz = $signed({2'b0, loc_ff[2]}) - (corner_bits[2] ? $signed(OneQ16) : 18'sd0);
   assign gval = dim3_ff ? grad3(tbl_rd, lx, ly, lz) : grad2(tbl_rd[2:0], lx, lz);

   // lerp tree stored in place: pairs (0,1)(2,3)(4,5)(6,7) then (0,2)(4,6) then (0,4)
   always_comb begin
      unique case (lidx_ff)
         3'd0: begin lo_a = 3'd0; lt = fade_ff[0]; la = cval_ff[0]; lb = cval_ff[1]; end
         3'd1: begin lo_a = 3'd2; lt = fade_ff[0]; la = cval_ff[2]; lb = cval_ff[3]; end
         3'd2: begin lo_a = 3'd4; lt = fade_ff[0]; la = cval_ff[4]; lb = cval_ff[5]; end
         3'd3: begin lo_a = 3'd6; lt = fade_ff[0]; la = cval_ff[6]; lb = cval_ff[7]; end
         3'd4: begin lo_a = 3'd0; lt = fade_ff[1]; la = cval_ff[0]; lb = cval_ff[2]; end
         3'd5: begin lo_a = 3'd4; lt = fade_ff[1]; la = cval_ff[4]; lb = cval_ff[6]; end
         default: begin lo_a = 3'd0; lt = fade_ff[2]; la = cval_ff[0]; lb = cval_ff[4]; end
      endcase
   end
   assign ldiff   = 21'(lb) - 21'(la);
   assign lprod_c = 41'(ldiff) * $signed({24'd0, lt});
   assign lres    = 21'(la) + 21'(lprod_ff >>> 16);

   assign wprod      = 39'(octval_ff) * $signed({22'd0, amp_ff});
   assign freq_next  = 48'(freq_ff) * 48'(lacun_ff);
   assign amp_next   = 33'(amp_ff) * 33'(persist_ff);
   // running total including the octave being accumulated
   assign total_next = total_ff + 53'(wprod);
   assign abs_total  = total_next[52] ? 53'(-total_next) : 53'(total_next);
   assign div_num    = abs_total;
   assign res_s      = neg_ff ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

   // sequencer
   always_comb begin
      state_in  = state_ff;
      tbl_req   = '0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req_cmd == CMD_LOAD) begin
                  tbl_req.wr_en   = 1'b1;
                  tbl_req.wr_addr = req_table_index;
                  tbl_req.wr_data = req_table_value;
               end else if (oct_sat == 4'd0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCALE_LO;
               end
            end
         end
         ST_SCALE_LO: state_in = ST_SCALE_HI;
         ST_SCALE_HI: state_in = ST_SPLIT;
         ST_SPLIT:    state_in = ST_FADE1;
         ST_FADE1:    state_in = ST_FADE2;
         ST_FADE2:    state_in = ST_FADE3;
         ST_FADE3:    state_in = ST_FADE4;
         ST_FADE4:    state_in = (axis_ff == 2'd2) ? ST_HASH_ISSUE : ST_SCALE_LO;
         ST_HASH_ISSUE: begin
            tbl_req.rd_en   = 1'b1;
            tbl_req.rd_addr = hacc_ff + c_sel;
            state_in = ST_HASH_WAIT;
         end
         ST_HASH_WAIT: state_in = (hstep_ff == last_step) ? ST_GRAD : ST_HASH_ISSUE;
         ST_GRAD: state_in = (corner_ff == (dim3_ff ? 4'd7 : 4'd3)) ? ST_LERP_MUL
                                                                 : ST_HASH_ISSUE;
         ST_LERP_MUL: state_in = ST_LERP_ADD;
         ST_LERP_ADD: state_in = (lidx_ff == 3'd6) ? ST_ACC : ST_LERP_MUL;
         ST_ACC:  state_in = ST_NEXT;
         ST_NEXT: begin
            if (oct_left_ff == 4'd1) begin
               state_in  = ST_DIV;
               div_start = 1'b1;
            end else begin
               state_in = ST_SCALE_LO;
            end
         end
         ST_DIV:  state_in = div_done ? ST_IDLE : ST_DIV;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= (state_ff == ST_DONE) || (state_ff == ST_DIV && div_done);
      end
   end

   // datapath updates
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            cx_ff[0]    <= req_coord_x;
            cx_ff[1]    <= req_coord_y;
            cx_ff[2]    <= req_coord_z;
            dim3_ff     <= three_d_ff;
            oct_left_ff <= oct_sat;
            freq_ff     <= 32'd4096;
            amp_ff      <= 17'd65536;
            amp_sum_ff  <= '0;
            total_ff    <= '0;
            axis_ff     <= three_d_ff ? 2'd0 : 2'd0;
            rsp_noise_value <= '0;
         end
         ST_SCALE_LO: prod_lo_ff <= mul_lo;
         ST_SCALE_HI: scaled_ff <= ((64'(mul_hi) <<< 16) + 64'(prod_lo_ff)) >>> 12;
         ST_SPLIT: begin
            cell_ff[axis_ff] <= scaled_u[CoordFracBits +: 8];
            loc_ff[axis_ff]  <= frac16;
         end
         ST_FADE1: t2_ff <= 32'(t2c[31:16]);
         ST_FADE2: begin
            t3_ff   <= 32'(t3c >> 16);
            poly_ff <= 34'(poly_c)
                       - 34'($signed({18'd0, loc_ff[axis_ff]}) * 34'sd15) + 34'sd655360;
         end
         ST_FADE3: ;
         ST_FADE4: begin
            fade_ff[axis_ff] <= fade_sat;
            if (axis_ff == 2'd2) begin
               corner_ff <= '0;
               hstep_ff  <= '0;
               hacc_ff   <= '0;
            end else begin
               axis_ff <= (dim3_ff || axis_ff == 2'd1) ? axis_ff + 2'd1 : 2'd2;
            end
         end
         ST_HASH_ISSUE: ;
         ST_HASH_WAIT: begin
            if (hstep_ff == last_step) begin
               hstep_ff <= '0;
               hacc_ff  <= '0;
            end else begin
               hstep_ff <= hstep_ff + 2'd1;
               hacc_ff  <= tbl_rd;
            end
         end
         ST_GRAD: begin
            cval_ff[corner_bits] <= gval;
            corner_ff <= corner_ff + 4'd1;
            lidx_ff   <= dim3_ff ? 3'd0 : 3'd0;
         end
         ST_LERP_MUL: lprod_ff <= lprod_c;
         ST_LERP_ADD: begin
            cval_ff[lo_a] <= 20'(lres);
            // 2D: bottom (0), top (2), then the final z blend (6)
            lidx_ff <= (!dim3_ff && lidx_ff == 3'd0) ? 3'd2
                     : (!dim3_ff && lidx_ff == 3'd2) ? 3'd6 : lidx_ff + 3'd1;
         end
         ST_ACC: begin
            octval_ff <= (cval_ff[0] > 20'sd65536) ? 20'sd65536
                       : (cval_ff[0] < -20'sd65536) ? -20'sd65536 : cval_ff[0];
         end
         ST_NEXT: begin
            total_ff    <= total_next;
            amp_sum_ff  <= amp_sum_ff + 21'(amp_ff);
            amp_ff      <= 17'(amp_next >> 16);
            freq_ff     <= (freq_next[47:12] > 36'hFFFFFFFF) ? 32'hFFFFFFFF
                                                              : freq_next[43:12];
            oct_left_ff <= oct_left_ff - 4'd1;
            axis_ff     <= 2'd0;
            neg_ff      <= total_next[52];
         end
         ST_DIV: begin
            neg_ff <= neg_ff;
            if (div_done) begin
               rsp_noise_value <= (res_s > 54'sd32767) ? 16'sh7FFF
                                : (res_s < -54'sd32768) ? -16'sh8000 : 16'(res_s);
            end
         end
         default: ;
      endcase
   end

   // assertions
   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (acc && req_cmd == CMD_LOAD) |=> !busy) else $error("load left block busy");
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (acc && req_cmd == CMD_EVAL) |=> busy) else $error("evaluate not started");
endmodule
`default_nettype wire

// ===== sv/fgn_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fgn_table (
   input  wire                   clock,
   input  fgn_pkg::tbl_req_type  req,
   output logic [7:0]            rd_data
);
   import fgn_pkg::*;

   logic [7:0] mem [TableSize];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data <= mem[req.rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== sv/fgn_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider for the final normalization: |num| / den, one bit per cycle.
module fgn_divider (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   input  wire [52:0]   num,
   input  wire [21:0]   den,
   output logic         done,
   output logic [52:0]  quot
);
   import fgn_pkg::*;

   logic [52:0] q_ff, q_in;
   logic [22:0] r_ff, r_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [22:0] trial;

   always_comb begin
      q_in   = q_ff;
      r_in   = r_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done   = 1'b0;
      trial  = {r_ff[21:0], q_ff[52]};
      if (start) begin
         q_in   = num;
         r_in   = '0;
         cnt_in = 6'd53;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, den}) begin
            r_in = trial - {1'b0, den};
            q_in = {q_ff[51:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[51:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in = 1'b0;
            done   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign quot = q_in;
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import fgn_pkg::*;

   // Noise scoreboard: mirrors table and registers, predicts each noise value
   class noise_scoreboard;
      logic [7:0]  perm_tbl [256];
      logic        three_d;
      logic [3:0]  octaves;
      logic [15:0] persist;
      logic [15:0] lacun;
      shortint     pending_noise [$];
      int          errors;
      int          n_eval;
      int          n_load;

      function new();
         three_d = 1'b1;
         octaves = 4'd4;
         persist = 16'd32768;
         lacun   = 16'd8192;
         errors  = 0;
         n_eval  = 0;
         n_load  = 0;
         foreach (perm_tbl[i]) perm_tbl[i] = 8'd0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            CSR_THREE_D:     three_d = data[0];
            CSR_OCTAVES:     octaves = data[3:0];
            CSR_PERSISTENCE: persist = data;
            CSR_LACUNARITY:  lacun   = data;
            default: ;
         endcase
      endfunction

      function longint lookup(longint i);
         return longint'(perm_tbl[i & 255]);
      endfunction

      function longint fade(longint t);
         longint t2, t3, poly, f;
         t2 = (t * t) >>> 16;
         t3 = (t2 * t) >>> 16;
         poly = ((6 * t * t) >>> 16) - 15 * t + 10 * 65536;
         f = (t3 * poly) >>> 16;
         if (f > 65536) f = 65536;
         return f;
      endfunction

      function longint blend(longint a, longint b, longint t);
         return a + (((b - a) * t) >>> 16);
      endfunction

      function longint dot2(longint h, longint x, longint z);
         case (h & 7)
            0: return x + z;
            1: return -x + z;
            2: return x - z;
            3: return -x - z;
            4: return x;
            5: return -x;
            6: return z;
            default: return -z;
         endcase
      endfunction

      function longint dot3(longint h, longint x, longint y, longint z);
         case (h % 12)
            0: return x + y;
            1: return -x + y;
            2: return x - y;
            3: return -x - y;
            4: return x + z;
            5: return -x + z;
            6: return x - z;
            7: return -x - z;
            8: return y + z;
            9: return -y + z;
            10: return y - z;
            default: return -y - z;
         endcase
      endfunction

      function longint clamp1(longint v);
         if (v > 65536) return 65536;
         if (v < -65536) return -65536;
         return v;
      endfunction

      // one octave; s[] holds scaled x, y, z
      function longint octave_value(longint s [3]);
         longint c [3], n [3], l [3], f [3], corner [8], a, b, r0, r1;
         longint bottom, top, h;
         for (int i = 0; i < 3; i++) begin
            c[i] = (s[i] >>> 16) & 255;
            l[i] = s[i] & 16'hFFFF;
            n[i] = (c[i] + 1) & 255;
            f[i] = fade(l[i]);
         end
         if (!three_d) begin
            bottom = blend(dot2(lookup(lookup(c[0]) + c[2]), l[0], l[2]),
               dot2(lookup(lookup(n[0]) + c[2]), l[0] - 65536, l[2]), f[0]);
            top = blend(dot2(lookup(lookup(c[0]) + n[2]), l[0], l[2] - 65536),
               dot2(lookup(lookup(n[0]) + n[2]), l[0] - 65536, l[2] - 65536), f[0]);
            return clamp1(blend(bottom, top, f[2]));
         end
         for (int i = 0; i < 8; i++) begin
            h = lookup(lookup(lookup(i[0] ? n[0] : c[0]) + (i[1] ? n[1] : c[1]))
                       + (i[2] ? n[2] : c[2]));
            corner[i] = dot3(h, l[0] - (i[0] ? 65536 : 0), l[1] - (i[1] ? 65536 : 0),
                             l[2] - (i[2] ? 65536 : 0));
         end
         a  = blend(corner[0], corner[1], f[0]);
         b  = blend(corner[2], corner[3], f[0]);
         r0 = blend(a, b, f[1]);
         a  = blend(corner[4], corner[5], f[0]);
         b  = blend(corner[6], corner[7], f[0]);
         r1 = blend(a, b, f[1]);
         return clamp1(blend(r0, r1, f[2]));
      endfunction

      // accepted request: update table or queue the expected noise value
      function void note_request(logic cmd, logic [7:0] idx, logic [7:0] val,
            logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
         longint crd [3], s [3], total, amp_sum, amp, freq, res;
         int oct;
         if (cmd == CMD_LOAD) begin
            perm_tbl[idx] = val;
            n_load++;
            return;
         end
         crd[0] = longint'(x);
         crd[1] = longint'(y);
         crd[2] = longint'(z);
         total = 0;
         amp_sum = 0;
         amp = 65536;
         freq = 4096;
         oct = (octaves > MaxOctaves) ? MaxOctaves : int'(octaves);
         for (int o = 0; o < oct; o++) begin
            for (int i = 0; i < 3; i++) s[i] = (crd[i] * freq) >>> 12;
            total += octave_value(s) * amp;
            amp_sum += amp;
            amp = (amp * longint'(persist)) >>> 16;
            freq = (freq * longint'(lacun)) >>> 12;
            if (freq > 64'hFFFF_FFFF) freq = 64'hFFFF_FFFF;
         end
         if (oct == 0 || amp_sum == 0) begin
            res = 0;
         end else begin
            res = total / (2 * amp_sum);
            if (res > 32767) res = 32767;
            if (res < -32768) res = -32768;
         end
         pending_noise.push_back(shortint'(res));
         n_eval++;
      endfunction

      function void check_noise(shortint got);
         shortint want;
         if (pending_noise.size() == 0) begin
            $error("noise_value: no response expected, actual %0d", got);
            errors++;
            return;
         end
         want = pending_noise.pop_front();
         if (got !== want) begin
            $error("noise_value: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_cmd = 1'b0;
   logic [7:0]         req_table_index = '0;
   logic [7:0]         req_table_value = '0;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic signed [31:0] req_coord_z = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_noise_value;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;

   noise_scoreboard sb = new();
   int idle_pct = 0;

   fractal_gradient_noise dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_table_index(req_table_index),
      .req_table_value(req_table_value), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .rsp_valid(rsp_valid), .rsp_noise_value(rsp_noise_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // responses are sampled mid-cycle, away from the driving edge
   always @(negedge clock) begin
      if (!reset && rsp_valid) sb.check_noise(rsp_noise_value);
   end

   // timeout
   initial begin
      #30ms;
      $display("fractal_gradient_noise test failed");
      $finish;
   end

   // one request; start stays high afterwards unless a gap follows
   task automatic send_request(logic cmd, logic [7:0] idx, logic [7:0] val,
         logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
      logic free;
      start <= 1'b1;
      req_cmd <= cmd;
      req_table_index <= idx;
      req_table_value <= val;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      do begin
         @(negedge clock);
         free = !busy;
         @(posedge clock);
      end while (!free);
      sb.note_request(cmd, idx, val, x, y, z);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic eval_point(logic signed [31:0] x, logic signed [31:0] y,
         logic signed [31:0] z);
      send_request(CMD_EVAL, 8'($urandom), 8'($urandom), x, y, z);
   endtask

   // drop start, wait for every response and for the block to go idle
   task automatic drain();
      logic idle;
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_noise.size() != 0) @(posedge clock);
      do begin
         @(negedge clock);
         idle = !busy;
         @(posedge clock);
      end while (!idle);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      logic rdy;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do begin
         @(negedge clock);
         rdy = csr_ready;
         @(posedge clock);
      end while (!rdy);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
   endtask

   task automatic set_mode(logic d3, logic [15:0] oct, logic [15:0] pers,
         logic [15:0] lac);
      drain();
      write_reg(CSR_THREE_D, {15'($urandom), d3});
      write_reg(CSR_OCTAVES, oct);
      write_reg(CSR_PERSISTENCE, pers);
      write_reg(CSR_LACUNARITY, lac);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(16'hFFFF)) - 32'sh8000;
         2: return {{8{$urandom_range(1) == 1}}, 24'($urandom)};
         default: return $signed({16'($urandom_range(16'h3FF)), 16'($urandom)})
                         - 32'sh0200_0000;
      endcase
   endfunction

   task automatic random_phase(int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 15)
            send_request(CMD_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom,
                         $urandom);
         else
            eval_point(rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole permutation table first so no entry is read unwritten
      for (int i = 0; i < 256; i++)
         send_request(CMD_LOAD, i[7:0], 8'(($urandom & 8'hFF) ^ i), 0, 0, 0);
      send_request(CMD_LOAD, 8'd0, 8'd255, 0, 0, 0);
      send_request(CMD_LOAD, 8'd255, 8'd0, 0, 0, 0);

      // directed points at reset settings: extremes, cell edges, signs
      eval_point(0, 0, 0);
      eval_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      eval_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      eval_point(-1, -1, -1);
      eval_point(1, 1, 1);
      eval_point(32'sh0000_8000, 32'sh0001_8000, -32'sh0000_8000);
      eval_point(32'sh00FF_FFFF, 32'sh00FF_0000, 32'sh0100_0000);
      eval_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      eval_point(32'sh0000_FFFF, 32'sh0001_0000, 32'shFFFF_0001);

      // 2D with maximum frequency growth, so frequency saturates
      set_mode(1'b0, 16'd8, 16'hFFFF, 16'hFFFF);
      eval_point(32'sh7FFF_FFFF, 0, 32'sh8000_0000);
      eval_point(32'sh0012_3456, 32'sh7FFF_0000, -32'sh0003_4567);
      random_phase(100);

      // zero octaves: every response is zero
      idle_pct = 53;
      set_mode(1'b1, 16'd0, 16'd0, 16'd0);
      eval_point(32'sh7FFF_FFFF, -1, 32'sh1234_5678);
      random_phase(50);

      // octave count above the maximum saturates; zero persistence and lacunarity
      set_mode(1'b1, 16'hFFFF, 16'd0, 16'd0);
      random_phase(60);

      idle_pct = 15;
      set_mode(1'b0, 16'hFFF1, 16'd0, 16'd4096);
      random_phase(105);

      idle_pct = 0;
      set_mode(1'b1, 16'd8, 16'hFFFF, 16'hFFFF);
      random_phase(105);

      idle_pct = 53;
      set_mode(1'b0, 16'($urandom_range(8)), 16'($urandom), 16'($urandom));
      random_phase(105);

      idle_pct = 15;
      set_mode(1'b1, 16'($urandom_range(2, 6)), 16'($urandom), 16'($urandom));
      random_phase(105);

      drain();
      repeat (1000) @(posedge clock);
      if (sb.pending_noise.size() != 0) begin
         $error("noise_value: %0d expected responses never arrived",
                sb.pending_noise.size());
         sb.errors++;
      end
      $display("Covered %0d evaluations and %0d table loads over 2D/3D modes,",
               sb.n_eval, sb.n_load);
      $display("octave counts 0..15, edge persistence/lacunarity and sender gaps.");
      if (sb.errors == 0) begin
         $display("fractal_gradient_noise test passed");
      end else begin
         $display("fractal_gradient_noise test failed");
      end
      $finish;
   end
endmodule
